### design/irmidi_pkg.sv
package irmidi_pkg;

	// Block dimensions.
	localparam int SENSORS = 1;
	localparam int WINDOW  = 7;
	localparam int MAX_CH  = 7;

	localparam int SAMPLE_W = 10;
	localparam int VEL_W    = 7;
	localparam int CH_W     = 3;
	localparam int POS_W    = $clog2(WINDOW);
	localparam int LVL_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W = 3;

	// Register reset values.
	localparam logic [SAMPLE_W-1:0] HAND_THRESHOLD_RST = 10'd190;
	localparam logic [SAMPLE_W-1:0] NEAR_BAND_LOW_RST  = 10'd220;
	localparam logic [SAMPLE_W-1:0] NEAR_BAND_HIGH_RST = 10'd300;
	localparam logic [SAMPLE_W-1:0] FAR_BAND_LOW_RST   = 10'd340;
	localparam logic [VEL_W-1:0]    NOTE_VELOCITY_RST  = 7'd64;
	localparam logic [SAMPLE_W-1:0] WINDOW_MIN_RST     = '1;

	localparam logic [BYTE_W-1:0] NOTE_ON_BASE = 8'h90;
	localparam logic [BYTE_W-1:0] NOTE_OFF_VEL = 8'h00;

	// Pitch levels.
	localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
	localparam logic [LVL_W-1:0] LVL_ONE  = 2'd1;
	localparam logic [LVL_W-1:0] LVL_TWO  = 2'd2;

	// Request kinds.
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HAND_THRESHOLD = 3'd0,
		CFG_NEAR_BAND_LOW  = 3'd1,
		CFG_NEAR_BAND_HIGH = 3'd2,
		CFG_FAR_BAND_LOW   = 3'd3,
		CFG_NOTE_VELOCITY  = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		MSG_STATUS   = 2'd0,
		MSG_NOTE     = 2'd1,
		MSG_VELOCITY = 2'd2
	} msg_byte_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_TICK,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic                req_type;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] midi_byte;
		logic              last_byte;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic sample_update;
		logic tick_scan;
		logic emit_byte;
	} dp_cmd_t;

	typedef struct packed {
		logic mask_empty;
		logic slot_free;
	} dp_status_t;

	localparam logic [BYTE_W-1:0] NOTE_ROW_ONE [MAX_CH] = '{
		8'h48, 8'h4a, 8'h4c, 8'h4d, 8'h4f, 8'h51, 8'h53
	};
	localparam logic [BYTE_W-1:0] NOTE_ROW_TWO [MAX_CH] = '{
		8'h3c, 8'h3e, 8'h40, 8'h41, 8'h43, 8'h45, 8'h47
	};

	// Level one uses the upper row; any other level uses the lower row.
	function automatic logic [BYTE_W-1:0] note_lookup(input logic [LVL_W-1:0] level,
		input logic [CH_W-1:0] ch);
		logic [CH_W-1:0] idx;
		idx = (ch == CH_W'(MAX_CH)) ? '0 : ch;
		if (level == LVL_ONE) begin
			note_lookup = NOTE_ROW_ONE[idx];
		end else begin
			note_lookup = NOTE_ROW_TWO[idx];
		end
	endfunction

endpackage

### design/ir_hand_sensor_to_midi_notes.sv
// Infrared hand sensor to MIDI note messages.
// Input channel (in_valid, in_stall, in_data): each transaction is either a converter
// sample for the current sensor channel or a timer tick. A transaction is taken when
// in_valid is high and in_stall is low. A sample occupies the block for a capture and then
// a window update; it yields no output. Every WINDOW samples close one window: the window
// minimum sets the channel's hand flag and pitch level, and the next channel is selected.
// A tick is captured and scanned, then three bytes (status, note, velocity) go out per
// channel whose hand flag changed with a nonzero level, one byte per cycle while the
// receiver takes them, and the sequencer then returns to idle. The single output
// register sets that byte rate.
// Output channel (out_valid, out_stall, out_data): midi_byte with last_byte high on the
// final byte of a tick's run. While out_stall is high the pending byte holds and the
// sequencer waits; a sample can still be taken while the final byte waits.
// Configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready; it is to
// be written only while the block is idle, which the block itself does not enforce. Reset
// clears the hand flags, levels, the window and out_valid, and restores the register defaults.
module ir_hand_sensor_to_midi_notes (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  irmidi_pkg::in_item_t              in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output irmidi_pkg::out_item_t             out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [irmidi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irmidi_pkg::SAMPLE_W-1:0]   cfg_data
);

	irmidi_pkg::dp_cmd_t    cmd;
	irmidi_pkg::dp_status_t status;

	// Registers can be written at any cycle; the user only writes them while idle.
	assign cfg_ready = 1'b1;

	irmidi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (in_data.req_type),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	irmidi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

`ifndef SYNTHESIS
	// A byte is never loaded over one the receiver has not yet taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_byte |-> status.slot_free)
		else $error("output byte loaded while the pending byte is stalled");

	// Every captured transaction is processed in the following cycle.
	a_capture_then_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (cmd.sample_update || cmd.tick_scan))
		else $error("captured transaction not processed");

	// A new byte appears only while the sequencer holds off the input channel.
	a_rose_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_stall)
		else $error("output byte appeared while the input channel was open");
`endif

endmodule

### design/irmidi_ctrl.sv
module irmidi_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   req_type,
	output logic                   in_stall,
	input  irmidi_pkg::dp_status_t status,
	output irmidi_pkg::dp_cmd_t    cmd
);

	irmidi_pkg::ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irmidi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			irmidi_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (req_type == irmidi_pkg::REQ_TICK) ?
						irmidi_pkg::ST_TICK : irmidi_pkg::ST_SAMPLE;
				end
			end
			irmidi_pkg::ST_SAMPLE: begin
				state_nxt = irmidi_pkg::ST_IDLE;
			end
			irmidi_pkg::ST_TICK: begin
				state_nxt = irmidi_pkg::ST_EMIT;
			end
			irmidi_pkg::ST_EMIT: begin
				if (status.mask_empty) begin
					state_nxt = irmidi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = irmidi_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			irmidi_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			irmidi_pkg::ST_SAMPLE: begin
				cmd.sample_update = 1'b1;
			end
			irmidi_pkg::ST_TICK: begin
				cmd.tick_scan = 1'b1;
			end
			irmidi_pkg::ST_EMIT: begin
				cmd.emit_byte = !status.mask_empty && status.slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

### design/irmidi_dp.sv
module irmidi_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  irmidi_pkg::in_item_t                 in_data,
	input  logic                                 cfg_valid,
	input  logic [irmidi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [irmidi_pkg::SAMPLE_W-1:0]      cfg_data,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output irmidi_pkg::out_item_t                out_data,
	input  irmidi_pkg::dp_cmd_t                  cmd,
	output irmidi_pkg::dp_status_t               status
);

	// Configuration registers.
	logic [irmidi_pkg::SAMPLE_W-1:0] hand_thr_q, near_low_q, near_high_q, far_low_q;
	logic [irmidi_pkg::VEL_W-1:0]    velocity_q;

	// Sample window state.
	logic [irmidi_pkg::SAMPLE_W-1:0] sample_q;
	logic [irmidi_pkg::SAMPLE_W-1:0] win_min_q;
	logic [irmidi_pkg::POS_W-1:0]    pos_q;
	logic [irmidi_pkg::CH_W-1:0]     ch_q;

	// Per-channel state.
	logic [irmidi_pkg::MAX_CH-1:0]   hand_q;
	logic [irmidi_pkg::MAX_CH-1:0]   before_q;
	logic [irmidi_pkg::LVL_W-1:0]    level_q [irmidi_pkg::MAX_CH];

	// Snapshot taken on a tick for the message run.
	logic [irmidi_pkg::MAX_CH-1:0]   mask_q;
	logic [irmidi_pkg::MAX_CH-1:0]   dir_on_q;
	logic [irmidi_pkg::LVL_W-1:0]    lvl_snap_q [irmidi_pkg::MAX_CH];
	irmidi_pkg::msg_byte_t           msg_q;

	logic                            out_valid_q;
	irmidi_pkg::out_item_t           out_data_q;

	logic [irmidi_pkg::SAMPLE_W-1:0] new_min;
	logic                            window_end;
	logic                            level_one_hit;
	logic                            level_two_hit;
	logic [irmidi_pkg::MAX_CH-1:0]   tick_mask;
	logic [irmidi_pkg::CH_W-1:0]     ch_e;
	logic [irmidi_pkg::MAX_CH-1:0]   mask_rest;
	logic [irmidi_pkg::BYTE_W-1:0]   byte_nxt;

	always_comb begin
		new_min = win_min_q;
		if (pos_q < irmidi_pkg::POS_W'(irmidi_pkg::WINDOW - 1) && sample_q < win_min_q) begin
			new_min = sample_q;
		end
		window_end    = (pos_q == irmidi_pkg::POS_W'(irmidi_pkg::WINDOW - 2));
		level_one_hit = (new_min > near_low_q) && (new_min < near_high_q);
		level_two_hit = (new_min > far_low_q);
	end

	// A channel takes part in the run when its hand flag changed and it has a level.
	always_comb begin
		tick_mask = '0;
		for (int i = 0; i < irmidi_pkg::SENSORS; i++) begin
			tick_mask[i] = (hand_q[i] ^ before_q[i]) && (level_q[i] != irmidi_pkg::LVL_NONE);
		end
	end

	always_comb begin
		ch_e = '0;
		for (int i = irmidi_pkg::MAX_CH - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				ch_e = irmidi_pkg::CH_W'(i);
			end
		end
		mask_rest = mask_q & ~(irmidi_pkg::MAX_CH'(1) << ch_e);
	end

	always_comb begin
		case (msg_q)
			irmidi_pkg::MSG_STATUS: begin
				byte_nxt = irmidi_pkg::NOTE_ON_BASE + {5'd0, ch_e};
			end
			irmidi_pkg::MSG_NOTE: begin
				byte_nxt = irmidi_pkg::note_lookup(lvl_snap_q[ch_e], ch_e);
			end
			irmidi_pkg::MSG_VELOCITY: begin
				byte_nxt = dir_on_q[ch_e] ? {1'b0, velocity_q} : irmidi_pkg::NOTE_OFF_VEL;
			end
			default: begin
				byte_nxt = irmidi_pkg::NOTE_OFF_VEL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_thr_q  <= irmidi_pkg::HAND_THRESHOLD_RST;
			near_low_q  <= irmidi_pkg::NEAR_BAND_LOW_RST;
			near_high_q <= irmidi_pkg::NEAR_BAND_HIGH_RST;
			far_low_q   <= irmidi_pkg::FAR_BAND_LOW_RST;
			velocity_q  <= irmidi_pkg::NOTE_VELOCITY_RST;
		end else if (cfg_valid) begin
			case (irmidi_pkg::cfg_index_t'(cfg_index))
				irmidi_pkg::CFG_HAND_THRESHOLD: hand_thr_q  <= cfg_data;
				irmidi_pkg::CFG_NEAR_BAND_LOW:  near_low_q  <= cfg_data;
				irmidi_pkg::CFG_NEAR_BAND_HIGH: near_high_q <= cfg_data;
				irmidi_pkg::CFG_FAR_BAND_LOW:   far_low_q   <= cfg_data;
				irmidi_pkg::CFG_NOTE_VELOCITY:  velocity_q  <= cfg_data[irmidi_pkg::VEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min_q <= irmidi_pkg::WINDOW_MIN_RST;
			pos_q     <= '0;
			ch_q      <= '0;
			hand_q    <= '0;
			before_q  <= '0;
			for (int i = 0; i < irmidi_pkg::MAX_CH; i++) begin
				level_q[i] <= irmidi_pkg::LVL_NONE;
			end
		end else begin
			if (cmd.sample_update) begin
				pos_q <= (pos_q == irmidi_pkg::POS_W'(irmidi_pkg::WINDOW - 1)) ?
					'0 : pos_q + irmidi_pkg::POS_W'(1);
				if (window_end) begin
					hand_q[ch_q] <= (new_min > hand_thr_q);
					if (level_one_hit) begin
						level_q[ch_q] <= irmidi_pkg::LVL_ONE;
					end else if (level_two_hit) begin
						level_q[ch_q] <= irmidi_pkg::LVL_TWO;
					end
					win_min_q <= irmidi_pkg::WINDOW_MIN_RST;
					ch_q <= (ch_q == irmidi_pkg::CH_W'(irmidi_pkg::SENSORS - 1)) ?
						'0 : ch_q + irmidi_pkg::CH_W'(1);
				end else begin
					win_min_q <= new_min;
				end
			end
			if (cmd.tick_scan) begin
				for (int i = 0; i < irmidi_pkg::SENSORS; i++) begin
					before_q[i] <= hand_q[i];
					if (!hand_q[i] && before_q[i]) begin
						level_q[i] <= irmidi_pkg::LVL_NONE;
					end
				end
			end
		end
	end

	// Message run sequencing and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			msg_q       <= irmidi_pkg::MSG_STATUS;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.tick_scan) begin
				mask_q <= tick_mask;
				msg_q  <= irmidi_pkg::MSG_STATUS;
			end else if (cmd.emit_byte) begin
				case (msg_q)
					irmidi_pkg::MSG_STATUS:   msg_q <= irmidi_pkg::MSG_NOTE;
					irmidi_pkg::MSG_NOTE:     msg_q <= irmidi_pkg::MSG_VELOCITY;
					default: begin
						msg_q  <= irmidi_pkg::MSG_STATUS;
						mask_q <= mask_rest;
					end
				endcase
			end
			if (cmd.emit_byte) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_data.sample;
		end
		if (cmd.tick_scan) begin
			dir_on_q <= hand_q;
			for (int i = 0; i < irmidi_pkg::MAX_CH; i++) begin
				lvl_snap_q[i] <= level_q[i];
			end
		end
		if (cmd.emit_byte) begin
			out_data_q.midi_byte <= byte_nxt;
			out_data_q.last_byte <= (msg_q == irmidi_pkg::MSG_VELOCITY) && (mask_rest == '0);
		end
	end

	assign status.mask_empty = (mask_q == '0);
	assign status.slot_free  = !out_valid_q || !out_stall;
	assign out_valid         = out_valid_q;
	assign out_data          = out_data_q;

endmodule
